/* rtl/core/spt_pkg.sv */
// Package for the semiprime test core: microcode control word, status
// bits and the read-only program that the sequencer steps through.
// No dependencies; used by spt_sequencer and semiprime_test_core.
package spt_pkg;

  // Default candidate width
  localparam int NUMBER_WIDTH_DEF = 16;

  // Program counter width and program length
  localparam int PC_W = 4;

  // Jump conditions of one control word
  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_ACCEPT,
    COND_LT4,
    COND_BUSY,
    COND_D_GT_Q,
    COND_REM_ZERO,
    COND_OUT_BUSY
  } cond_e;

  // One microcode word: jump condition, jump target and datapath actions
  typedef struct packed {
    cond_e            cond;
    logic [PC_W-1:0]  target;
    logic             load_in;    // take a candidate, reset trial divisor
    logic             div_start;  // launch one division x / d
    logic             inc_d;      // advance trial divisor
    logic             load_cof;   // cofactor becomes x, divisor back to 2
    logic             set_semi;   // verdict is semiprime
    logic             emit;       // write the result register
  } ctrl_t;

  // Datapath status seen by the sequencer
  typedef struct packed {
    logic accept;    // input transfer this cycle
    logic lt4;       // candidate below four
    logic busy;      // divider still iterating
    logic d_gt_q;    // trial divisor above quotient: d*d > x
    logic rem_zero;  // divisor divides x
    logic out_busy;  // result register still full
  } status_t;

  // Program step addresses
  localparam logic [PC_W-1:0] ST_WAIT     = 4'd0;
  localparam logic [PC_W-1:0] ST_SMALL    = 4'd1;
  localparam logic [PC_W-1:0] ST_DIV1     = 4'd2;
  localparam logic [PC_W-1:0] ST_BUSY1    = 4'd3;
  localparam logic [PC_W-1:0] ST_END1     = 4'd4;
  localparam logic [PC_W-1:0] ST_HIT1     = 4'd5;
  localparam logic [PC_W-1:0] ST_NEXT1    = 4'd6;
  localparam logic [PC_W-1:0] ST_COF      = 4'd7;
  localparam logic [PC_W-1:0] ST_DIV2     = 4'd8;
  localparam logic [PC_W-1:0] ST_BUSY2    = 4'd9;
  localparam logic [PC_W-1:0] ST_END2     = 4'd10;
  localparam logic [PC_W-1:0] ST_HIT2     = 4'd11;
  localparam logic [PC_W-1:0] ST_NEXT2    = 4'd12;
  localparam logic [PC_W-1:0] ST_SEMI     = 4'd13;
  localparam logic [PC_W-1:0] ST_EMIT     = 4'd14;
  localparam logic [PC_W-1:0] ST_RET      = 4'd15;

  // Build one control word
  function automatic ctrl_t uword(cond_e c, logic [PC_W-1:0] t, logic [5:0] act);
    ctrl_t w;
    w.cond      = c;
    w.target    = t;
    w.load_in   = act[5];
    w.div_start = act[4];
    w.inc_d     = act[3];
    w.load_cof  = act[2];
    w.set_semi  = act[1];
    w.emit      = act[0];
    return w;
  endfunction

  // Microcode program: smallest divisor search, then primality of cofactor
  function automatic ctrl_t ucode(logic [PC_W-1:0] pc);
    ctrl_t w;
    case (pc)
      ST_WAIT:  w = uword(COND_NO_ACCEPT, ST_WAIT,  6'b100000);
      ST_SMALL: w = uword(COND_LT4,       ST_EMIT,  6'b000000);
      ST_DIV1:  w = uword(COND_NEVER,     ST_WAIT,  6'b010000);
      ST_BUSY1: w = uword(COND_BUSY,      ST_BUSY1, 6'b000000);
      ST_END1:  w = uword(COND_D_GT_Q,    ST_EMIT,  6'b000000);
      ST_HIT1:  w = uword(COND_REM_ZERO,  ST_COF,   6'b000000);
      ST_NEXT1: w = uword(COND_ALWAYS,    ST_DIV1,  6'b001000);
      ST_COF:   w = uword(COND_NEVER,     ST_WAIT,  6'b000100);
      ST_DIV2:  w = uword(COND_NEVER,     ST_WAIT,  6'b010000);
      ST_BUSY2: w = uword(COND_BUSY,      ST_BUSY2, 6'b000000);
      ST_END2:  w = uword(COND_D_GT_Q,    ST_SEMI,  6'b000000);
      ST_HIT2:  w = uword(COND_REM_ZERO,  ST_EMIT,  6'b000000);
      ST_NEXT2: w = uword(COND_ALWAYS,    ST_DIV2,  6'b001000);
      ST_SEMI:  w = uword(COND_NEVER,     ST_WAIT,  6'b000010);
      ST_EMIT:  w = uword(COND_OUT_BUSY,  ST_EMIT,  6'b000001);
      ST_RET:   w = uword(COND_ALWAYS,    ST_WAIT,  6'b000000);
      default:  w = uword(COND_ALWAYS,    ST_WAIT,  6'b000000);
    endcase
    return w;
  endfunction

endpackage

/* rtl/core/spt_divider.sv */
// Restoring divider for the semiprime test core: one quotient bit per cycle.
// Standalone; instantiated by semiprime_test_core.
module spt_divider #(
  parameter int NumberWidth = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [NumberWidth-1:0] dividend_i,
  input  logic [NumberWidth-1:0] divisor_i,
  output logic                   busy_o,
  output logic [NumberWidth-1:0] quotient_o,
  output logic [NumberWidth-1:0] remainder_o
);

  localparam int CntW = $clog2(NumberWidth + 1);

  logic [CntW-1:0]        cnt_q, cnt_d;
  logic [NumberWidth-1:0] quo_q, quo_d;
  logic [NumberWidth-1:0] rem_q, rem_d;
  logic [NumberWidth-1:0] div_q, div_d;
  logic [NumberWidth:0]   shifted;
  logic [NumberWidth:0]   diff;

  // Shift in the next dividend bit and try a subtract
  always_comb begin
    shifted = {rem_q, quo_q[NumberWidth-1]};
    diff    = shifted - {1'b0, div_q};
    cnt_d   = cnt_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    div_d   = div_q;
    if (start_i) begin
      cnt_d = CntW'(NumberWidth);
      quo_d = dividend_i;
      rem_d = '0;
      div_d = divisor_i;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
      quo_d = {quo_q[NumberWidth-2:0], ~diff[NumberWidth]};
      rem_d = diff[NumberWidth] ? shifted[NumberWidth-1:0] : diff[NumberWidth-1:0];
    end
  end

  // Hold the iteration count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign busy_o      = (cnt_q != '0);
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

/* rtl/core/spt_sequencer.sv */
// Microcode sequencer for the semiprime test core: step counter, program
// table and jump logic. Depends on spt_pkg.
module spt_sequencer
  import spt_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  status_t status_i,
  output ctrl_t   ctrl_o
);

  logic [PC_W-1:0] pc_q, pc_d;
  ctrl_t           ctrl;
  logic            jump;

  // Fetch the current control word
  assign ctrl   = ucode(pc_q);
  assign ctrl_o = ctrl;

  // Evaluate the jump condition and pick the next step
  always_comb begin
    case (ctrl.cond)
      COND_NEVER:     jump = 1'b0;
      COND_ALWAYS:    jump = 1'b1;
      COND_NO_ACCEPT: jump = ~status_i.accept;
      COND_LT4:       jump = status_i.lt4;
      COND_BUSY:      jump = status_i.busy;
      COND_D_GT_Q:    jump = status_i.d_gt_q;
      COND_REM_ZERO:  jump = status_i.rem_zero;
      COND_OUT_BUSY:  jump = status_i.out_busy;
      default:        jump = 1'b0;
    endcase
    pc_d = jump ? ctrl.target : pc_q + 1'b1;
  end

  // Step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= ST_WAIT;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

/* rtl/core/semiprime_test_core.sv */
// Semiprime test core, top level: stream ports, datapath registers, divider
// and microcode sequencer. Depends on spt_pkg, spt_divider, spt_sequencer.
//
// Usage: one candidate per transfer on the s_axis side; tdata carries the
// candidate, tuser marks the first number of an interval (clears the found
// flag before this number is judged), tlast marks the last number. Each
// candidate gives one transfer on the m_axis side: tdata carries the number,
// its semiprime verdict and the interval's found flag; tlast echoes the last
// mark. The verdict comes from trial division: the smallest divisor d with
// d*d <= n is searched, then its cofactor is tested for primality.
// A trial runs a start step, a wait step that holds while the shared bit-serial
// divider iterates, and three check steps; this loop sets the rate. An item takes
// t1 + t2 trials, t1 and t2 being the trial counts of both searches (each at most
// sqrt(n)); numbers below four skip the search.
// One item is processed at a time; the next candidate is taken once the
// result has been written to the output register, so a stalled receiver
// holds at most one result and one candidate. Reset clears the found flag,
// the output valid and the sequencer.
module semiprime_test_core
  import spt_pkg::*;
#(
  parameter int NumberWidth = NUMBER_WIDTH_DEF,
  localparam int InDataW    = ((NumberWidth + 7) / 8) * 8,
  localparam int OutDataW   = ((NumberWidth + 2 + 7) / 8) * 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // candidate
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  // first_of_range
  input  logic                s_axis_tuser_i,
  input  logic                s_axis_tlast_i,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // number_out, is_semiprime, any_found
  output logic [OutDataW-1:0] m_axis_tdata_o,
  output logic                m_axis_tlast_o,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i
);

  ctrl_t                  ctrl;
  status_t                status;
  logic                   accept;
  logic                   div_busy;
  logic [NumberWidth-1:0] quo, rem;

  logic [NumberWidth-1:0] num_q, x_q, d_q;
  logic                   semi_q, first_q, last_q;
  logic                   found_q, found_d;
  logic                   out_valid_q;
  logic [NumberWidth-1:0] out_num_q;
  logic                   out_semi_q, out_found_q, out_last_q;
  logic                   do_emit;

  assign s_axis_tready_o = ctrl.load_in;
  assign accept          = s_axis_tvalid_i & ctrl.load_in;
  assign do_emit         = ctrl.emit & ~out_valid_q;

  // Status for the sequencer
  always_comb begin
    status.accept   = accept;
    status.lt4      = (num_q < NumberWidth'(4));
    status.busy     = div_busy;
    status.d_gt_q   = (d_q > quo);
    status.rem_zero = (rem == '0);
    status.out_busy = out_valid_q;
  end

  spt_sequencer u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl)
  );

  spt_divider #(
    .NumberWidth (NumberWidth)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (ctrl.div_start),
    .dividend_i  (x_q),
    .divisor_i   (d_q),
    .busy_o      (div_busy),
    .quotient_o  (quo),
    .remainder_o (rem)
  );

  // Candidate, trial divisor and verdict
  always_ff @(posedge clk_i) begin
    if (accept) begin
      num_q   <= s_axis_tdata_i[NumberWidth-1:0];
      x_q     <= s_axis_tdata_i[NumberWidth-1:0];
      d_q     <= NumberWidth'(2);
      semi_q  <= 1'b0;
      first_q <= s_axis_tuser_i;
      last_q  <= s_axis_tlast_i;
    end else if (ctrl.load_cof) begin
      x_q <= quo;
      d_q <= NumberWidth'(2);
    end else if (ctrl.inc_d) begin
      d_q <= d_q + 1'b1;
    end else if (ctrl.set_semi) begin
      semi_q <= 1'b1;
    end
  end

  // Clear the found flag on an interval start, then gather the verdict
  assign found_d = (found_q & ~first_q) | semi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (do_emit) begin
        found_q     <= found_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (do_emit) begin
      out_num_q   <= num_q;
      out_semi_q  <= semi_q;
      out_found_q <= found_d;
      out_last_q  <= last_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tdata_o  = {{(OutDataW - NumberWidth - 2){1'b0}},
                            out_found_q, out_semi_q, out_num_q};

endmodule
